// ----- rtl/bvm_pkg.sv -----
package bvm_pkg;

	// classified operation codes carried from front to back
	typedef logic [3:0] op_t;

	localparam op_t OP_RESTART = 4'd0;
	localparam op_t OP_MOV     = 4'd1;
	localparam op_t OP_COPY    = 4'd2;
	localparam op_t OP_ADD     = 4'd3;
	localparam op_t OP_INC     = 4'd4;
	localparam op_t OP_DEC     = 4'd5;
	localparam op_t OP_SUB     = 4'd6;
	localparam op_t OP_CMP     = 4'd7;
	localparam op_t OP_CMPI    = 4'd8;
	localparam op_t OP_JMP     = 4'd9;
	localparam op_t OP_JEQ     = 4'd10;
	localparam op_t OP_JLT     = 4'd11;
	localparam op_t OP_JGT     = 4'd12;
	localparam op_t OP_JNE     = 4'd13;
	localparam op_t OP_RET     = 4'd14;
	localparam op_t OP_BAD     = 4'd15;

	// opcode bytes as fetched
	localparam logic [7:0] FUNC_MOV  = 8'h10;
	localparam logic [7:0] FUNC_COPY = 8'h20;
	localparam logic [7:0] FUNC_ADD  = 8'h30;
	localparam logic [7:0] FUNC_INC  = 8'h31;
	localparam logic [7:0] FUNC_DEC  = 8'h32;
	localparam logic [7:0] FUNC_SUB  = 8'h33;
	localparam logic [7:0] FUNC_CMP  = 8'h40;
	localparam logic [7:0] FUNC_CMPI = 8'h41;
	localparam logic [7:0] FUNC_JMP  = 8'h50;
	localparam logic [7:0] FUNC_JEQ  = 8'h51;
	localparam logic [7:0] FUNC_JLT  = 8'h52;
	localparam logic [7:0] FUNC_JGT  = 8'h53;
	localparam logic [7:0] FUNC_JNE  = 8'h54;
	localparam logic [7:0] FUNC_RET  = 8'h99;

	// argument registers loaded on restart
	localparam logic [7:0] ARG_COUNT_REG = 8'd10;
	localparam logic [7:0] ARG_VALUE_REG = 8'd11;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// configuration register select values, compared with paddr[3]
	localparam logic CFG_ARG_COUNT = 1'b0;
	localparam logic CFG_ARG_VALUE = 1'b1;

	typedef struct packed {
		op_t        op;
		logic [7:0] rd;
		logic [7:0] ra;
		logic [7:0] rb;
		logic [7:0] imm;
	} bvm_item_t;

	typedef struct packed {
		logic [63:0] arg_count;
		logic [63:0] arg_value;
	} bvm_cfg_t;

endpackage

// ----- rtl/bvm_front.sv -----
module bvm_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              restart,
	input  logic [7:0]        func,
	input  logic [7:0]        byte_one,
	input  logic [7:0]        byte_two,
	input  logic [7:0]        byte_three,
	input  logic              q_full,
	output logic              q_push,
	output bvm_pkg::bvm_item_t q_item
);
	import bvm_pkg::*;

	// accept whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// classify the opcode and route operand bytes to read ports
	always_comb begin
		q_item     = '0;
		q_item.rd  = byte_one;
		q_item.imm = byte_two;
		if (restart) begin
			q_item.op = OP_RESTART;
		end else begin
			unique case (func) inside
				FUNC_MOV: begin
					q_item.op = OP_MOV;
				end
				FUNC_COPY: begin
					q_item.op = OP_COPY;
					q_item.ra = byte_two;
				end
				FUNC_ADD, FUNC_SUB: begin
					q_item.op = (func == FUNC_ADD) ? OP_ADD : OP_SUB;
					q_item.ra = byte_two;
					q_item.rb = byte_three;
				end
				FUNC_INC, FUNC_DEC: begin
					q_item.op = (func == FUNC_INC) ? OP_INC : OP_DEC;
					q_item.ra = byte_one;
				end
				FUNC_CMP: begin
					q_item.op = OP_CMP;
					q_item.ra = byte_one;
					q_item.rb = byte_two;
				end
				FUNC_CMPI: begin
					q_item.op = OP_CMPI;
					q_item.ra = byte_one;
				end
				FUNC_JMP: begin
					q_item.op  = OP_JMP;
					q_item.imm = byte_one;
				end
				FUNC_JEQ: begin
					q_item.op  = OP_JEQ;
					q_item.imm = byte_one;
				end
				FUNC_JLT: begin
					q_item.op  = OP_JLT;
					q_item.imm = byte_one;
				end
				FUNC_JGT: begin
					q_item.op  = OP_JGT;
					q_item.imm = byte_one;
				end
				FUNC_JNE: begin
					q_item.op  = OP_JNE;
					q_item.imm = byte_one;
				end
				FUNC_RET: begin
					q_item.op = OP_RET;
					q_item.ra = ARG_VALUE_REG;
				end
				default: begin
					q_item.op = OP_BAD;
				end
			endcase
		end
	end

endmodule

// ----- rtl/bvm_queue.sv -----
module bvm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bvm_pkg::bvm_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output bvm_pkg::bvm_item_t head_item
);
	import bvm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	bvm_item_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/bvm_back.sv -----
module bvm_back #(
	parameter int REGISTER_COUNT = 16,
	parameter int REGISTER_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bvm_pkg::bvm_cfg_t  cfg,
	input  logic               head_valid,
	input  bvm_pkg::bvm_item_t head_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [8:0]         next_pointer,
	output logic               halted,
	output logic [63:0]        return_value,
	output logic               bad_opcode
);
	import bvm_pkg::*;

	localparam int IDX_W = $clog2(REGISTER_COUNT);

	// where a read port takes its operand from
	localparam logic [1:0] SRC_MEM   = 2'd0;
	localparam logic [1:0] SRC_FWD   = 2'd1;
	localparam logic [1:0] SRC_CLEAR = 2'd2;
	localparam logic [1:0] SRC_ZERO  = 2'd3;

	logic [REGISTER_WIDTH-1:0] regs_q [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] valid_q;
	logic [REGISTER_WIDTH-1:0] shadow_count_q;
	logic [REGISTER_WIDTH-1:0] shadow_value_q;
	logic [2:0]                flags_q;
	logic [8:0]                ip_q;

	logic                      s1_valid_q;
	bvm_item_t                 item_s1;
	logic [REGISTER_WIDTH-1:0] raw_a_s1;
	logic [REGISTER_WIDTH-1:0] raw_b_s1;
	logic [REGISTER_WIDTH-1:0] fwd_s1;
	logic [1:0]                src_a_s1;
	logic [1:0]                src_b_s1;

	logic                      out_valid_q;
	logic [8:0]                next_pointer_q;
	logic                      halted_q;
	logic [63:0]               return_value_q;
	logic                      bad_opcode_q;

	logic                      exec_fire;
	logic                      exec_restart;
	logic                      wen;
	logic [IDX_W-1:0]          w_idx;
	logic [REGISTER_WIDTH-1:0] wdata;
	logic                      writes_reg;
	logic [IDX_W-1:0]          a_idx;
	logic [IDX_W-1:0]          b_idx;
	logic                      a_ok;
	logic                      b_ok;
	logic [1:0]                src_a_d;
	logic [1:0]                src_b_d;
	logic [REGISTER_WIDTH-1:0] clr_a;
	logic [REGISTER_WIDTH-1:0] clr_b;
	logic [REGISTER_WIDTH-1:0] va;
	logic [REGISTER_WIDTH-1:0] vb;
	logic [REGISTER_WIDTH-1:0] imm_w;
	logic [REGISTER_WIDTH-1:0] cmp_b;
	logic [2:0]                flags_d;
	logic                      take;
	logic [8:0]                ip_d;

	// pipeline advance
	assign exec_fire    = s1_valid_q && (!out_valid_q || out_ready);
	assign pop          = head_valid && (!s1_valid_q || exec_fire);
	assign exec_restart = exec_fire && (item_s1.op == OP_RESTART);

	// read addresses of the queue head
	assign a_idx = head_item.ra[IDX_W-1:0];
	assign b_idx = head_item.rb[IDX_W-1:0];
	assign a_ok  = (head_item.ra < 8'(REGISTER_COUNT));
	assign b_ok  = (head_item.rb < 8'(REGISTER_COUNT));

	// operand source, with forwarding of the write retiring this cycle
	always_comb begin
		if (!a_ok) begin
			src_a_d = SRC_ZERO;
		end else if (exec_restart) begin
			src_a_d = SRC_CLEAR;
		end else if (wen && (w_idx == a_idx)) begin
			src_a_d = SRC_FWD;
		end else if (!valid_q[a_idx]) begin
			src_a_d = SRC_CLEAR;
		end else begin
			src_a_d = SRC_MEM;
		end
		if (!b_ok) begin
			src_b_d = SRC_ZERO;
		end else if (exec_restart) begin
			src_b_d = SRC_CLEAR;
		end else if (wen && (w_idx == b_idx)) begin
			src_b_d = SRC_FWD;
		end else if (!valid_q[b_idx]) begin
			src_b_d = SRC_CLEAR;
		end else begin
			src_b_d = SRC_MEM;
		end
	end

	// register file memory, registered read
	always_ff @(posedge clk) begin
		if (wen) begin
			regs_q[w_idx] <= wdata;
		end
		if (pop) begin
			raw_a_s1 <= regs_q[a_idx];
			raw_b_s1 <= regs_q[b_idx];
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1  <= head_item;
			fwd_s1   <= wdata;
			src_a_s1 <= src_a_d;
			src_b_s1 <= src_b_d;
		end
	end

	// read stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pop) begin
			s1_valid_q <= 1'b1;
		end else if (exec_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	// value of an entry not written since the last clear
	always_comb begin
		if (item_s1.ra == ARG_COUNT_REG) begin
			clr_a = shadow_count_q;
		end else if (item_s1.ra == ARG_VALUE_REG) begin
			clr_a = shadow_value_q;
		end else begin
			clr_a = '0;
		end
		if (item_s1.rb == ARG_COUNT_REG) begin
			clr_b = shadow_count_q;
		end else if (item_s1.rb == ARG_VALUE_REG) begin
			clr_b = shadow_value_q;
		end else begin
			clr_b = '0;
		end
	end

	// operand select
	always_comb begin
		case (src_a_s1)
			SRC_MEM:   va = raw_a_s1;
			SRC_FWD:   va = fwd_s1;
			SRC_CLEAR: va = clr_a;
			default:   va = '0;
		endcase
		case (src_b_s1)
			SRC_MEM:   vb = raw_b_s1;
			SRC_FWD:   vb = fwd_s1;
			SRC_CLEAR: vb = clr_b;
			default:   vb = '0;
		endcase
	end

	assign imm_w = REGISTER_WIDTH'(item_s1.imm);
	assign cmp_b = (item_s1.op == OP_CMPI) ? imm_w : vb;
	assign w_idx = item_s1.rd[IDX_W-1:0];

	// execute: write data, flags and next pointer
	always_comb begin
		writes_reg = 1'b0;
		wdata      = '0;
		flags_d    = flags_q;
		take       = 1'b0;
		ip_d       = ip_q;
		unique case (item_s1.op) inside
			OP_RESTART: begin
				flags_d = '0;
				ip_d    = '0;
			end
			OP_MOV: begin
				writes_reg = 1'b1;
				wdata      = imm_w;
				ip_d       = ip_q + 9'd3;
			end
			OP_COPY: begin
				writes_reg = 1'b1;
				wdata      = va;
				ip_d       = ip_q + 9'd3;
			end
			OP_ADD: begin
				writes_reg = 1'b1;
				wdata      = va + vb;
				ip_d       = ip_q + 9'd4;
			end
			OP_SUB: begin
				writes_reg = 1'b1;
				wdata      = va - vb;
				ip_d       = ip_q + 9'd4;
			end
			OP_INC: begin
				writes_reg = 1'b1;
				wdata      = va + REGISTER_WIDTH'(1);
				ip_d       = ip_q + 9'd2;
			end
			OP_DEC: begin
				writes_reg = 1'b1;
				wdata      = va - REGISTER_WIDTH'(1);
				ip_d       = ip_q + 9'd2;
			end
			OP_CMP, OP_CMPI: begin
				flags_d = {va > cmp_b, va == cmp_b, va < cmp_b};
				ip_d    = ip_q + 9'd3;
			end
			OP_JMP, OP_JEQ, OP_JLT, OP_JGT, OP_JNE: begin
				case (item_s1.op)
					OP_JMP:  take = 1'b1;
					OP_JEQ:  take = flags_q[1];
					OP_JLT:  take = flags_q[0] && !flags_q[1];
					OP_JGT:  take = flags_q[2] && !flags_q[1];
					default: take = !flags_q[1];
				endcase
				ip_d = take ? {1'b0, item_s1.imm} : ip_q + 9'd2;
			end
			default: begin
				// return and undefined opcodes leave the state alone
			end
		endcase
	end

	assign wen = exec_fire && writes_reg && (item_s1.rd < 8'(REGISTER_COUNT));

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			shadow_count_q <= '0;
			shadow_value_q <= '0;
			flags_q        <= '0;
			ip_q           <= '0;
		end else if (exec_fire) begin
			flags_q <= flags_d;
			ip_q    <= ip_d;
			if (exec_restart) begin
				valid_q        <= '0;
				shadow_count_q <= cfg.arg_count[REGISTER_WIDTH-1:0];
				shadow_value_q <= cfg.arg_value[REGISTER_WIDTH-1:0];
			end else if (wen) begin
				valid_q[w_idx] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			next_pointer_q <= ip_d;
			halted_q       <= (item_s1.op == OP_RET);
			return_value_q <= (item_s1.op == OP_RET) ? 64'(va) : '0;
			bad_opcode_q   <= (item_s1.op == OP_BAD);
		end
	end

	assign out_valid    = out_valid_q;
	assign next_pointer = next_pointer_q;
	assign halted       = halted_q;
	assign return_value = return_value_q;
	assign bad_opcode   = bad_opcode_q;

endmodule

// ----- rtl/bytecode_register_vm_execute.sv -----
// Execute stage of a small register bytecode machine.
// Input channel (in_valid/in_ready): one instruction per item, either a
// restart or an opcode with up to three operand bytes fetched at the
// current pointer. Output channel (out_valid/out_ready): one result per
// item with the next pointer, halted with register 11, and bad_opcode.
// Configuration: APB-style port, 64-bit data, argument_count at 0x0 and
// argument_value at 0x8; write only while no item is in flight.
// Path: queue, read stage and result register. Throughput: one item per
// cycle while the receiver does not stall, set by the register file memory
// with its registered read ports and a write forward from the retiring
// instruction. A two-entry queue parts the decode front from the execute
// back, and a result register holds the output; when the receiver stalls
// the back end holds, the queue fills and in_ready falls once it is full.
// Reset: registers, flags and pointer read as zero, argument_count is 1 and
// argument_value is 0; per-entry valid bits clear the register file at once,
// so no clearing pass is needed, and a restart item clears it the same way.
module bytecode_register_vm_execute #(
	parameter int REGISTER_COUNT = 16,
	parameter int REGISTER_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	input  logic [7:0]  func,
	input  logic [7:0]  byte_one,
	input  logic [7:0]  byte_two,
	input  logic [7:0]  byte_three,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  next_pointer,
	output logic        halted,
	output logic [63:0] return_value,
	output logic        bad_opcode,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import bvm_pkg::*;

	bvm_cfg_t  cfg_q;
	bvm_item_t q_item;
	bvm_item_t head_item;
	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      head_valid;
	logic      cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arg_count <= 64'd1;
			cfg_q.arg_value <= 64'd0;
		end else if (cfg_wr) begin
			if (paddr[3] == CFG_ARG_VALUE) begin
				cfg_q.arg_value <= pwdata;
			end else begin
				cfg_q.arg_count <= pwdata;
			end
		end
	end

	assign prdata = (paddr[3] == CFG_ARG_COUNT) ? cfg_q.arg_count : cfg_q.arg_value;

	// decode front
	bvm_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.func       (func),
		.byte_one   (byte_one),
		.byte_two   (byte_two),
		.byte_three (byte_three),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	// queue between front and back
	bvm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// execute back
	bvm_back #(
		.REGISTER_COUNT (REGISTER_COUNT),
		.REGISTER_WIDTH (REGISTER_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_pointer (next_pointer),
		.halted       (halted),
		.return_value (return_value),
		.bad_opcode   (bad_opcode)
	);

endmodule

// ----- rtl/bvm_checker.sv -----
module bvm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [8:0]  next_pointer,
	input logic        halted,
	input logic [63:0] return_value,
	input logic        bad_opcode,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [63:0] pwdata,
	input logic [63:0] prdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pointer) && $stable(halted)
			&& $stable(return_value) && $stable(bad_opcode))
		else $error("result changed while stalled");

	// a return and an undefined opcode never share an item
	a_halt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(halted && bad_opcode))
		else $error("halted and bad_opcode together");

	// return value is zero unless halted
	a_ret_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !halted |-> return_value == 64'd0)
		else $error("return value without halt");

	// a written register reads back at once
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) ##1 (psel && !pwrite && paddr == $past(paddr))
			|-> prdata == $past(pwdata))
		else $error("configuration read-back mismatch");

endmodule

bind bytecode_register_vm_execute bvm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.next_pointer (next_pointer),
	.halted       (halted),
	.return_value (return_value),
	.bad_opcode   (bad_opcode),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import bvm_pkg::*;

	localparam int MODEL_REG_COUNT = 16;
	localparam logic [3:0] ADDR_ARG_COUNT = {CFG_ARG_COUNT, 3'b000};
	localparam logic [3:0] ADDR_ARG_VALUE = {CFG_ARG_VALUE, 3'b000};
	localparam int FLAG_LT = 0;
	localparam int FLAG_EQ = 1;
	localparam int FLAG_GT = 2;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int MAX_PRINTS = 100;

	typedef struct packed {
		logic [8:0]  pointer;
		logic        halted;
		logic [63:0] ret_value;
		logic        bad;
	} vm_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        restart;
	logic [7:0]  func;
	logic [7:0]  byte_one;
	logic [7:0]  byte_two;
	logic [7:0]  byte_three;
	logic        out_valid;
	logic        out_ready;
	logic [8:0]  next_pointer;
	logic        halted;
	logic [63:0] return_value;
	logic        bad_opcode;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// machine state as the testbench expects it
	logic [63:0] vm_regs [MODEL_REG_COUNT];
	logic [2:0]  vm_flags;
	logic [8:0]  vm_pointer;
	logic [63:0] cfg_arg_count;
	logic [63:0] cfg_arg_value;

	vm_result_t pending_results [$];
	int fail_count;
	int send_idle_pct;
	int recv_stall_pct;

	bytecode_register_vm_execute DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.func         (func),
		.byte_one     (byte_one),
		.byte_two     (byte_two),
		.byte_three   (byte_three),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_pointer (next_pointer),
		.halted       (halted),
		.return_value (return_value),
		.bad_opcode   (bad_opcode),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	always #10 clk = ~clk;

	// run limit
	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	// register file access, out of range reads give zero and writes are lost
	function automatic logic [63:0] read_reg(input logic [7:0] idx);
		if (idx < MODEL_REG_COUNT)
			return vm_regs[idx[3:0]];
		return 64'd0;
	endfunction

	function automatic void write_reg(input logic [7:0] idx, input logic [63:0] value);
		if (idx < MODEL_REG_COUNT)
			vm_regs[idx[3:0]] = value;
	endfunction

	function automatic void set_flags(input logic [63:0] a, input logic [63:0] b);
		vm_flags = '0;
		vm_flags[FLAG_LT] = a < b;
		vm_flags[FLAG_EQ] = a == b;
		vm_flags[FLAG_GT] = a > b;
	endfunction

	function automatic void jump_to(input logic taken, input logic [7:0] target);
		if (taken)
			vm_pointer = {1'b0, target};
		else
			vm_pointer = vm_pointer + 9'd2;
	endfunction

	// executes one instruction on the expected state and gives its result
	function automatic vm_result_t execute_instruction(input logic rs, input logic [7:0] f,
			input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
		vm_result_t res;
		res = '0;
		if (rs) begin
			for (int i = 0; i < MODEL_REG_COUNT; i++)
				vm_regs[i] = 64'd0;
			vm_flags = '0;
			vm_pointer = '0;
			write_reg(ARG_COUNT_REG, cfg_arg_count);
			write_reg(ARG_VALUE_REG, cfg_arg_value);
		end else begin
			case (f)
				FUNC_MOV: begin
					write_reg(b1, {56'd0, b2});
					vm_pointer = vm_pointer + 9'd3;
				end
				FUNC_COPY: begin
					write_reg(b1, read_reg(b2));
					vm_pointer = vm_pointer + 9'd3;
				end
				FUNC_ADD: begin
					write_reg(b1, read_reg(b2) + read_reg(b3));
					vm_pointer = vm_pointer + 9'd4;
				end
				FUNC_INC: begin
					write_reg(b1, read_reg(b1) + 64'd1);
					vm_pointer = vm_pointer + 9'd2;
				end
				FUNC_DEC: begin
					write_reg(b1, read_reg(b1) - 64'd1);
					vm_pointer = vm_pointer + 9'd2;
				end
				FUNC_SUB: begin
					write_reg(b1, read_reg(b2) - read_reg(b3));
					vm_pointer = vm_pointer + 9'd4;
				end
				FUNC_CMP: begin
					set_flags(read_reg(b1), read_reg(b2));
					vm_pointer = vm_pointer + 9'd3;
				end
				FUNC_CMPI: begin
					set_flags(read_reg(b1), {56'd0, b2});
					vm_pointer = vm_pointer + 9'd3;
				end
				FUNC_JMP: jump_to(1'b1, b1);
				FUNC_JEQ: jump_to(vm_flags[FLAG_EQ], b1);
				FUNC_JLT: jump_to(vm_flags[FLAG_LT] && !vm_flags[FLAG_EQ], b1);
				FUNC_JGT: jump_to(vm_flags[FLAG_GT] && !vm_flags[FLAG_EQ], b1);
				FUNC_JNE: jump_to(!vm_flags[FLAG_EQ], b1);
				FUNC_RET: begin
					res.halted = 1'b1;
					res.ret_value = read_reg(ARG_VALUE_REG);
				end
				default: res.bad = 1'b1;
			endcase
		end
		res.pointer = vm_pointer;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < MAX_PRINTS)
			$display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// one instruction item, with a random gap in front of it
	task automatic send_item(input logic rs, input logic [7:0] f, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		restart    <= rs;
		func       <= f;
		byte_one   <= b1;
		byte_two   <= b2;
		byte_three <= b3;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(execute_instruction(rs, f, b1, b2, b3));
	endtask

	task automatic send_op(input logic [7:0] f, input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3);
		send_item(1'b0, f, b1, b2, b3);
	endtask

	// hold the input and let every outstanding result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [3:0] addr, input logic [63:0] data);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_ARG_COUNT)
			cfg_arg_count = data;
		else
			cfg_arg_value = data;
		@(posedge clk);
	endtask

	function automatic logic [63:0] random_wide();
		case ($urandom_range(3))
			0: return 64'd0;
			1: return ALL_ONES;
			2: return 64'($urandom_range(255));
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// mostly valid register numbers, now and then one out of range
	function automatic logic [7:0] pick_reg();
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255));
		return 8'($urandom_range(MODEL_REG_COUNT - 1));
	endfunction

	// one instruction of a random program, with some restarts, returns and noise
	task automatic send_random_instruction();
		int pick;
		logic [7:0] f, b1, b2, b3;
		logic [63:0] reg_value;
		pick = $urandom_range(99);
		b1 = pick_reg();
		b2 = pick_reg();
		b3 = pick_reg();
		if (pick < 3) begin
			send_item(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255)));
		end else if (pick < 9) begin
			send_op(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255)));
		end else if (pick < 11) begin
			send_op(FUNC_RET, b1, b2, b3);
		end else begin
			case ($urandom_range(12))
				0: f = FUNC_MOV;
				1: f = FUNC_COPY;
				2: f = FUNC_ADD;
				3: f = FUNC_INC;
				4: f = FUNC_DEC;
				5: f = FUNC_SUB;
				6: f = FUNC_CMP;
				7: f = FUNC_CMPI;
				8: f = FUNC_JMP;
				9: f = FUNC_JEQ;
				10: f = FUNC_JLT;
				11: f = FUNC_JGT;
				default: f = FUNC_JNE;
			endcase
			if (f == FUNC_MOV)
				b2 = 8'($urandom_range(255));
			// an immediate compare often hits the register's own value
			if (f == FUNC_CMPI) begin
				reg_value = read_reg(b1);
				if (reg_value < 256 && $urandom_range(1) == 1)
					b2 = reg_value[7:0];
				else
					b2 = 8'($urandom_range(255));
			end
			if (f == FUNC_JMP || f == FUNC_JEQ || f == FUNC_JLT || f == FUNC_JGT
					|| f == FUNC_JNE)
				b1 = 8'($urandom_range(255));
			send_op(f, b1, b2, b3);
		end
	endtask

	// return and copy from the state left by reset, then a restart with reset config
	task automatic test_reset_state();
		send_op(FUNC_RET, 8'd0, 8'd0, 8'd0);
		send_op(FUNC_COPY, 8'd0, ARG_COUNT_REG, 8'd0);
		send_item(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_op(FUNC_COPY, 8'd1, ARG_COUNT_REG, 8'd0);
		send_op(FUNC_RET, 8'd0, 8'd0, 8'd0);
		drain_results();
	endtask

	// argument registers at their extremes, loaded by restart
	task automatic test_argument_registers();
		write_config(ADDR_ARG_COUNT, ALL_ONES);
		write_config(ADDR_ARG_VALUE, ALL_ONES);
		send_item(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_op(FUNC_RET, 8'd0, 8'd0, 8'd0);
		send_op(FUNC_INC, ARG_COUNT_REG, 8'd0, 8'd0);
		send_op(FUNC_COPY, ARG_VALUE_REG, ARG_COUNT_REG, 8'd0);
		send_op(FUNC_RET, 8'd0, 8'd0, 8'd0);
		drain_results();
		write_config(ADDR_ARG_COUNT, 64'd0);
		write_config(ADDR_ARG_VALUE, 64'h8000_0000_0000_0000);
		send_item(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_op(FUNC_DEC, ARG_COUNT_REG, 8'd0, 8'd0);
		send_op(FUNC_ADD, ARG_VALUE_REG, ARG_VALUE_REG, ARG_VALUE_REG);
		send_op(FUNC_RET, 8'd0, 8'd0, 8'd0);
		drain_results();
	endtask

	// every operation, wrap-around, out of range registers, all jump outcomes
	task automatic test_directed_ops();
		write_config(ADDR_ARG_COUNT, ALL_ONES);
		write_config(ADDR_ARG_VALUE, 64'h0123_4567_89AB_CDEF);
		send_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_op(FUNC_MOV, 8'd0, 8'd255, 8'd255);
		send_op(FUNC_MOV, 8'd15, 8'd0, 8'd0);
		send_op(FUNC_MOV, 8'd16, 8'd7, 8'd0);
		send_op(FUNC_MOV, 8'd255, 8'd255, 8'd0);
		send_op(FUNC_COPY, 8'd1, ARG_COUNT_REG, 8'd0);
		send_op(FUNC_COPY, 8'd2, 8'd200, 8'd0);
		send_op(FUNC_ADD, 8'd3, 8'd1, 8'd1);
		send_op(FUNC_ADD, 8'd4, 8'd0, 8'd255);
		send_op(FUNC_INC, 8'd1, 8'd0, 8'd0);
		send_op(FUNC_DEC, 8'd2, 8'd0, 8'd0);
		send_op(FUNC_DEC, 8'd20, 8'd0, 8'd0);
		send_op(FUNC_SUB, 8'd5, 8'd15, 8'd0);
		send_op(FUNC_SUB, 8'd6, 8'd2, 8'd3);
		// greater
		send_op(FUNC_CMP, 8'd0, 8'd15, 8'd0);
		send_op(FUNC_JGT, 8'h80, 8'd0, 8'd0);
		send_op(FUNC_JLT, 8'h40, 8'd0, 8'd0);
		// less
		send_op(FUNC_CMP, 8'd15, 8'd0, 8'd0);
		send_op(FUNC_JLT, 8'h10, 8'd0, 8'd0);
		send_op(FUNC_JGT, 8'h20, 8'd0, 8'd0);
		// equal
		send_op(FUNC_CMPI, 8'd0, 8'd255, 8'd0);
		send_op(FUNC_JEQ, 8'h30, 8'd0, 8'd0);
		send_op(FUNC_JNE, 8'h31, 8'd0, 8'd0);
		send_op(FUNC_CMPI, 8'd0, 8'd0, 8'd0);
		send_op(FUNC_JNE, 8'hFF, 8'd0, 8'd0);
		send_op(FUNC_JEQ, 8'h00, 8'd0, 8'd0);
		send_op(FUNC_JMP, 8'hFF, 8'd0, 8'd0);
		send_op(8'h00, 8'd0, 8'd0, 8'd0);
		send_op(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_op(FUNC_RET, 8'd0, 8'd0, 8'd0);
		drain_results();
	endtask

	// pointer runs past 511 and wraps to zero
	task automatic test_pointer_wrap();
		send_item(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_op(FUNC_JMP, 8'hFF, 8'd0, 8'd0);
		repeat (63)
			send_op(FUNC_ADD, pick_reg(), pick_reg(), pick_reg());
		send_op(FUNC_CMP, 8'd1, 8'd2, 8'd0);
		send_op(FUNC_INC, 8'd3, 8'd0, 8'd0);
		send_op(FUNC_MOV, 8'd4, 8'd9, 8'd0);
		drain_results();
	endtask

	// random programs under one idling mix, config changed while idle
	task automatic test_random_phase(input int count, input int send_pct, input int recv_pct);
		drain_results();
		write_config(ADDR_ARG_COUNT, random_wide());
		write_config(ADDR_ARG_VALUE, random_wide());
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		send_item(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		for (int n = 0; n < count; n++) begin
			send_random_instruction();
			if ($urandom_range(149) == 0)
				drain_results();
		end
	endtask

	// receiver stalls
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// compare each result with the oldest expected one
	always @(posedge clk) begin : check_results
		vm_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {55'd0, next_pointer}, 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (next_pointer !== want.pointer)
					report_mismatch("next_pointer", {55'd0, next_pointer},
						{55'd0, want.pointer});
				if (halted !== want.halted)
					report_mismatch("halted", {63'd0, halted}, {63'd0, want.halted});
				if (return_value !== want.ret_value)
					report_mismatch("return_value", return_value, want.ret_value);
				if (bad_opcode !== want.bad)
					report_mismatch("bad_opcode", {63'd0, bad_opcode}, {63'd0, want.bad});
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		restart = 1'b0;
		func = 8'h00;
		byte_one = 8'h00;
		byte_two = 8'h00;
		byte_three = 8'h00;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < MODEL_REG_COUNT; i++)
			vm_regs[i] = 64'd0;
		vm_flags = '0;
		vm_pointer = '0;
		cfg_arg_count = 64'd1;
		cfg_arg_value = 64'd0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_argument_registers();
		test_directed_ops();
		test_pointer_wrap();
		test_random_phase(300, 0, 0);
		test_random_phase(300, 73, 0);
		test_random_phase(300, 0, 73);
		test_random_phase(300, 34, 34);

		// wait for the tail, then keep watching for anything stray
		in_valid <= 1'b0;
		for (int n = 0; n < 5000 && pending_results.size() != 0; n++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		while (pending_results.size() != 0) begin
			report_mismatch("result never came", 64'd0, {55'd0, pending_results[0].pointer});
			void'(pending_results.pop_front());
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bvm_pkg.sv
rtl/bvm_front.sv
rtl/bvm_queue.sv
rtl/bvm_back.sv
rtl/bytecode_register_vm_execute.sv
rtl/bvm_checker.sv
sim/tb.sv
